// ===== rtl/core/stable_priority_queue_top_assert.svh =====
`ifndef STABLE_PRIORITY_QUEUE_TOP_ASSERT_SVH
`define STABLE_PRIORITY_QUEUE_TOP_ASSERT_SVH

// clocked assertion, off while reset is high
`define SPQ_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("stable priority queue check failed");

// clocked assertion, also checked during reset
`define SPQ_ASSERT_ALWAYS(label, prop) \
   label: assert property (@(posedge clock) prop) \
      else $error("stable priority queue check failed");

`endif

// ===== rtl/core/spq_pkg.sv =====
package spq_pkg;

   localparam int DEPTH = 16;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int IDX_W = $clog2(DEPTH);

   typedef enum logic {
      KIND_INSERT = 1'b0,
      KIND_REMOVE = 1'b1
   } kind_type;

   typedef enum logic [1:0] {
      ST_INSERTED = 2'd0,
      ST_DROPPED  = 2'd1,
      ST_REMOVED  = 2'd2,
      ST_EMPTY    = 2'd3
   } status_type;

   typedef struct packed {
      kind_type    kind;
      logic [15:0] job_id;
      logic [15:0] page_count;
      logic [7:0]  priority_req;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic [15:0] out_id;
      logic [15:0] out_pages;
      logic [7:0]  out_priority;
      logic [4:0]  occupancy;
   } rsp_type;

   typedef struct packed {
      logic [15:0] id;
      logic [15:0] pages;
      logic [7:0]  prio;
   } slot_type;

   typedef struct packed {
      logic exec;
   } cmd_type;

   typedef enum logic {
      OUT_EMPTY = 1'b0,
      OUT_HELD  = 1'b1
   } out_state_type;

endpackage

// ===== rtl/core/spq_ctrl.sv =====
module spq_ctrl (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output spq_pkg::cmd_type cmd
);
   import spq_pkg::*;

   out_state_type state_ff;
   out_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= OUT_EMPTY;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         OUT_EMPTY: begin
            if (req_valid) begin
               state_in = OUT_HELD;
            end
         end
         OUT_HELD: begin
            if (rsp_ready && !req_valid) begin
               state_in = OUT_EMPTY;
            end
         end
         default: state_in = OUT_EMPTY;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         OUT_EMPTY: begin
            req_ready = 1'b1;
         end
         OUT_HELD: begin
            req_ready = rsp_ready;
            rsp_valid = 1'b1;
         end
         default: begin
            req_ready = 1'b0;
            rsp_valid = 1'b0;
         end
      endcase
      cmd.exec = req_valid && req_ready;
   end

endmodule

// ===== rtl/core/spq_datapath.sv =====
module spq_datapath (
   input  logic             clock,
   input  logic             reset,
   input  spq_pkg::cmd_type cmd,
   input  spq_pkg::req_type req,
   output spq_pkg::rsp_type rsp
);
   import spq_pkg::*;

   slot_type         slot_ff [DEPTH];
   slot_type         slot_in [DEPTH];
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   rsp_type          rsp_ff;
   rsp_type          rsp_in;
   logic [DEPTH-1:0] ahead;
   logic             full;
   logic             empty;
   slot_type         new_slot;

   assign full  = (count_ff == CNT_W'(DEPTH));
   assign empty = (count_ff == '0);
   assign new_slot = '{id: req.job_id, pages: req.page_count, prio: req.priority_req};

   // slots that stay ahead of a new job: occupied and not lower in priority
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         ahead[i] = (CNT_W'(i) < count_ff) && (slot_ff[i].prio <= req.priority_req);
      end
   end

   always_comb begin
      count_in = count_ff;
      rsp_in   = '{status: ST_INSERTED, out_id: '0, out_pages: '0,
                   out_priority: '0, occupancy: 5'(count_ff)};
      for (int i = 0; i < DEPTH; i++) begin
         slot_in[i] = slot_ff[i];
      end
      if (req.kind == KIND_INSERT) begin
         if (full) begin
            rsp_in.status = ST_DROPPED;
         end else begin
            for (int i = 0; i < DEPTH; i++) begin
               if (!ahead[i]) begin
                  if (i == 0) begin
                     slot_in[i] = new_slot;
                  end else if (ahead[IDX_W'(i - 1)]) begin
                     slot_in[i] = new_slot;
                  end else begin
                     slot_in[i] = slot_ff[IDX_W'(i - 1)];
                  end
               end
            end
            count_in = count_ff + CNT_W'(1);
            rsp_in.status    = ST_INSERTED;
            rsp_in.occupancy = 5'(count_in);
         end
      end else begin
         if (empty) begin
            rsp_in.status = ST_EMPTY;
         end else begin
            for (int i = 0; i < DEPTH - 1; i++) begin
               slot_in[i] = slot_ff[IDX_W'(i + 1)];
            end
            count_in = count_ff - CNT_W'(1);
            rsp_in.status       = ST_REMOVED;
            rsp_in.out_id       = slot_ff[0].id;
            rsp_in.out_pages    = slot_ff[0].pages;
            rsp_in.out_priority = slot_ff[0].prio;
            rsp_in.occupancy    = 5'(count_in);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.exec) begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         rsp_ff <= rsp_in;
         for (int i = 0; i < DEPTH; i++) begin
            slot_ff[i] <= slot_in[i];
         end
      end
   end

   assign rsp = rsp_ff;

endmodule

// ===== rtl/core/stable_priority_queue_top.sv =====
// Stable priority queue, jobs held sorted in a shift-register slot array.
// Result: valid in the cycle after the item is accepted.
// Throughput: 1 item per cycle while results are taken; slot compare and shift
// complete in the accept cycle, the result register holds one pending item.
// Reset: synchronous, clears job count and result valid; slot contents are not cleared.
module stable_priority_queue_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  spq_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output spq_pkg::rsp_type rsp_payload
);
   import spq_pkg::*;

   cmd_type cmd;

   spq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   spq_datapath u_datapath (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .req   (req_payload),
      .rsp   (rsp_payload)
   );

endmodule

// ===== rtl/core/spq_checker.sv =====
`include "stable_priority_queue_top_assert.svh"

module spq_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input spq_pkg::rsp_type rsp_payload
);
   import spq_pkg::*;

   `SPQ_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
   `SPQ_ASSERT_ALWAYS(a_ready_when_free, !reset && !rsp_valid |-> req_ready)
   `SPQ_ASSERT(a_zero_fields, rsp_valid && rsp_payload.status != ST_REMOVED |->
      rsp_payload.out_id == 16'd0 && rsp_payload.out_pages == 16'd0 &&
      rsp_payload.out_priority == 8'd0)
   `SPQ_ASSERT(a_empty_occ, rsp_valid && rsp_payload.status == ST_EMPTY |->
      rsp_payload.occupancy == 5'd0)
   `SPQ_ASSERT(a_full_occ, rsp_valid && rsp_payload.status == ST_DROPPED |->
      rsp_payload.occupancy == 5'(DEPTH))

endmodule

bind stable_priority_queue_top spq_checker u_checker (.*);
